>>> design/vnio_pkg.sv
package vnio_pkg;

    localparam int MAX_VERTS = 4096;
    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int COORD_W   = 24;
    localparam int POS_W     = 3 * COORD_W;
    localparam int SUM_W     = 64;
    localparam int THICK_W   = 23;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int CROSS_W   = 2 * DIFF_W + 1;
    localparam int MUL_W     = 32;
    localparam int R_W       = 31;
    localparam int LEN_W     = 33;
    localparam int QUO_W     = 25;
    localparam int NUM_W     = 56;
    localparam int REM_W     = LEN_W + 2;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_FACE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic CFG_THICK = 1'b0;
    localparam logic CFG_SIGN  = 1'b1;

    localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(4096);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FACE,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        op_t                        op;
        logic [IDX_W-1:0]           vi;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic [IDX_W-1:0]           ca;
        logic [IDX_W-1:0]           cb;
        logic [IDX_W-1:0]           cc;
    } item_t;

endpackage

>>> design/vnio_front.sv
module vnio_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [vnio_pkg::IDX_W-1:0]      vertex_index,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_x,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_y,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_z,
    input  logic [vnio_pkg::IDX_W-1:0]      corner_a,
    input  logic [vnio_pkg::IDX_W-1:0]      corner_b,
    input  logic [vnio_pkg::IDX_W-1:0]      corner_c,
    output vnio_pkg::item_t                 q_item,
    output logic                            q_valid,
    input  logic                            q_pop
);
    import vnio_pkg::*;

    item_t       ent_reg [2];
    item_t       new_item;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;

    always_comb
    begin
        new_item.vi = vertex_index;
        new_item.px = pos_in_x;
        new_item.py = pos_in_y;
        new_item.pz = pos_in_z;
        new_item.ca = corner_a;
        new_item.cb = corner_b;
        new_item.cc = corner_c;
        case (kind)
            KIND_LOAD:  new_item.op = OP_LOAD;
            KIND_FACE:  new_item.op = OP_FACE;
            KIND_QUERY: new_item.op = OP_QUERY;
            default:    new_item.op = OP_NOP;
        endcase
    end

    assign busy    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> design/vnio_back.sv
module vnio_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vnio_pkg::item_t                     q_item,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic [vnio_pkg::THICK_W-1:0]        thick,
    input  logic                                sign_cfg,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [vnio_pkg::COORD_W-1:0] off_x,
    output logic signed [vnio_pkg::COORD_W-1:0] off_y,
    output logic signed [vnio_pkg::COORD_W-1:0] off_z
);
    import vnio_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_FA,
        S_FB,
        S_FC,
        S_FM,
        S_FS,
        S_FW,
        S_QA,
        S_QM,
        S_QN,
        S_QS,
        S_QR,
        S_QDM,
        S_QDL,
        S_QDV
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [COORD_W+2:0] v);
        logic signed [COORD_W+2:0] hi;
        logic signed [COORD_W+2:0] lo;
        hi = (COORD_W+3)'(2 ** (COORD_W - 1) - 1);
        lo = -(COORD_W+3)'(2 ** (COORD_W - 1));
        if (v > hi)
            return COORD_W'(hi);
        else if (v < lo)
            return COORD_W'(lo);
        else
            return v[COORD_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic signed [CROSS_W-1:0] b);
        logic [SUM_W-1:0] be;
        logic [SUM_W-1:0] s;
        be = SUM_W'(b);
        s  = a + be;
        if (a[SUM_W-1] == be[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
            return a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            return s;
    endfunction

    logic [POS_W-1:0]     pos_mem [MAX_VERTS];
    logic [3*SUM_W-1:0]   sum_mem [MAX_VERTS];
    logic                 pos_we;
    logic [IDX_W-1:0]     pos_waddr;
    logic [POS_W-1:0]     pos_wdata;
    logic [IDX_W-1:0]     pos_raddr;
    logic [POS_W-1:0]     pos_rdata_reg;
    logic                 sum_we;
    logic [IDX_W-1:0]     sum_waddr;
    logic [3*SUM_W-1:0]   sum_wdata;
    logic [IDX_W-1:0]     sum_raddr;
    logic [3*SUM_W-1:0]   sum_rdata_reg;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 done_reg, done_next;
    logic [1:0]           kk_reg, kk_next;
    logic [4:0]           cnt_reg, cnt_next;

    item_t                item_reg, item_next;
    logic [1:0]           status_reg, status_next;
    logic signed [COORD_W-1:0] off_reg [3];
    logic signed [COORD_W-1:0] off_next [3];
    logic signed [COORD_W-1:0] pa_reg [3];
    logic signed [COORD_W-1:0] pa_next [3];
    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  u_next [3];
    logic signed [DIFF_W-1:0]  w_reg [3];
    logic signed [DIFF_W-1:0]  w_next [3];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic signed [CROSS_W-1:0] n_next [3];
    logic signed [2*MUL_W-1:0] prod_reg, prod_next;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [SUM_W-1:0]     r_reg [3];
    logic [SUM_W-1:0]     r_next [3];
    logic                 neg_reg [3];
    logic                 neg_next [3];
    logic [SUM_W-1:0]     m_reg, m_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [SUM_W-1:0]     res_reg, res_next;
    logic [SUM_W-1:0]     bit_reg, bit_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     numlo_reg, numlo_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [QUO_W-1:0]     q_reg [3];
    logic [QUO_W-1:0]     q_next [3];

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    always_comb
    begin
        logic signed [COORD_W-1:0] pv [3];
        logic [SUM_W-1:0]          sv [3];
        logic [IDX_W-1:0]          corner;
        logic [CNT_W-1:0]          vi_inc;
        logic [2:0]                idx;
        logic [SUM_W-1:0]          trial_sum;
        logic [NUM_W-1:0]          num;
        logic [REM_W-1:0]          trial;
        logic [REM_W-1:0]          dvs;
        logic [QUO_W-1:0]          quo_new;
        logic [SUM_W-1:0]          res_new;
        logic                      sub;
        logic signed [COORD_W+2:0] ext;

        pv[0] = pos_rdata_reg[3*COORD_W-1:2*COORD_W];
        pv[1] = pos_rdata_reg[2*COORD_W-1:COORD_W];
        pv[2] = pos_rdata_reg[COORD_W-1:0];
        sv[0] = sum_rdata_reg[3*SUM_W-1:2*SUM_W];
        sv[1] = sum_rdata_reg[2*SUM_W-1:SUM_W];
        sv[2] = sum_rdata_reg[SUM_W-1:0];
        case (kk_reg)
            2'd0:    corner = item_reg.ca;
            2'd1:    corner = item_reg.cb;
            default: corner = item_reg.cc;
        endcase
        vi_inc    = {1'b0, item_reg.vi} + CNT_W'(1);
        idx       = 3'(cnt_reg - 5'd1);
        dvs       = REM_W'({len_reg, 1'b0});
        trial     = {rem_reg[REM_W-2:0], numlo_reg[QUO_W-1]};
        quo_new   = {quo_reg[QUO_W-2:0], 1'b0};
        trial_sum = res_reg + bit_reg;
        res_new   = res_reg >> 1;
        num       = '0;
        sub       = 1'b0;
        ext       = '0;

        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        kk_next     = kk_reg;
        cnt_next    = cnt_reg;
        item_next   = item_reg;
        status_next = status_reg;
        off_next    = off_reg;
        pa_next     = pa_reg;
        u_next      = u_reg;
        w_next      = w_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        neg_next    = neg_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        numlo_next  = numlo_reg;
        quo_next    = quo_reg;
        q_next      = q_reg;
        q_pop       = 1'b0;
        mul_a       = MUL_W'(u_reg[1]);
        mul_b       = MUL_W'(w_reg[2]);
        pos_we      = 1'b0;
        pos_waddr   = item_reg.vi;
        pos_wdata   = {item_reg.px, item_reg.py, item_reg.pz};
        pos_raddr   = item_reg.vi;
        sum_we      = 1'b0;
        sum_waddr   = corner;
        sum_wdata   = '0;
        sum_raddr   = corner;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = ST_OK;
                off_next    = '{default: '0};
                case (item_reg.op)
                    OP_LOAD:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if ({1'b0, item_reg.vi} >= CNT_W'(MAX_VERTS))
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            pos_we    = 1'b1;
                            sum_we    = 1'b1;
                            sum_waddr = item_reg.vi;
                            if (vi_inc > count_reg)
                            begin
                                count_next = vi_inc;
                            end
                        end
                    end
                    OP_FACE:
                    begin
                        if ({1'b0, item_reg.ca} >= count_reg ||
                            {1'b0, item_reg.cb} >= count_reg ||
                            {1'b0, item_reg.cc} >= count_reg)
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            pos_raddr  = item_reg.ca;
                            state_next = S_FA;
                        end
                    end
                    OP_QUERY:
                    begin
                        if ({1'b0, item_reg.vi} >= count_reg)
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            sum_raddr  = item_reg.vi;
                            state_next = S_QA;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FA:
            begin
                pos_raddr  = item_reg.cb;
                pa_next    = pv;
                state_next = S_FB;
            end
            S_FB:
            begin
                pos_raddr = item_reg.cc;
                for (int i = 0; i < 3; i++)
                begin
                    u_next[i] = DIFF_W'(pv[i]) - DIFF_W'(pa_reg[i]);
                end
                state_next = S_FC;
            end
            S_FC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_next[i] = DIFF_W'(pv[i]) - DIFF_W'(pa_reg[i]);
                end
                cnt_next   = 5'd0;
                state_next = S_FM;
            end
            S_FM:
            begin
                case (cnt_reg)
                    5'd0:    begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(w_reg[2]); end
                    5'd1:    begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(w_reg[1]); end
                    5'd2:    begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(w_reg[0]); end
                    5'd3:    begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(w_reg[2]); end
                    5'd4:    begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(w_reg[1]); end
                    default: begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(w_reg[0]); end
                endcase
                if (cnt_reg != 5'd0)
                begin
                    if (!idx[0])
                        n_next[idx[2:1]] = CROSS_W'(prod_reg);
                    else
                        n_next[idx[2:1]] = n_reg[idx[2:1]] - CROSS_W'(prod_reg);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd6)
                begin
                    kk_next    = 2'd0;
                    state_next = S_FS;
                end
            end
            S_FS:
            begin
                state_next = S_FW;
            end
            S_FW:
            begin
                sum_we    = 1'b1;
                sum_wdata = {sat_add(sv[0], n_reg[0]), sat_add(sv[1], n_reg[1]),
                             sat_add(sv[2], n_reg[2])};
                if (kk_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    kk_next    = kk_reg + 2'd1;
                    state_next = S_FS;
                end
            end
            S_QA:
            begin
                pa_next = pv;
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = sv[i][SUM_W-1];
                    r_next[i]   = sv[i][SUM_W-1] ? (~sv[i] + SUM_W'(1)) : sv[i];
                end
                state_next = S_QM;
            end
            S_QM:
            begin
                m_next = r_reg[0];
                if (r_reg[1] > m_next)
                    m_next = r_reg[1];
                if (r_reg[2] > m_next)
                    m_next = r_reg[2];
                if (m_next == '0)
                begin
                    status_next = ST_ZERO;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_QN;
                end
            end
            S_QN:
            begin
                cnt_next = 5'd0;
                acc_next = '0;
                if (m_reg[SUM_W-1:R_W+8] != '0)
                begin
                    m_next = m_reg >> 8;
                    for (int i = 0; i < 3; i++) r_next[i] = r_reg[i] >> 8;
                end
                else if (m_reg[SUM_W-1:R_W] != '0)
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++) r_next[i] = r_reg[i] >> 1;
                end
                else if (m_reg[R_W-1:R_W-9] == '0)
                begin
                    m_next = m_reg << 8;
                    for (int i = 0; i < 3; i++) r_next[i] = r_reg[i] << 8;
                end
                else if (!m_reg[R_W-1])
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++) r_next[i] = r_reg[i] << 1;
                end
                else
                begin
                    state_next = S_QS;
                end
            end
            S_QS:
            begin
                case (cnt_reg)
                    5'd0:    mul_a = {1'b0, r_reg[0][R_W-1:0]};
                    5'd1:    mul_a = {1'b0, r_reg[1][R_W-1:0]};
                    default: mul_a = {1'b0, r_reg[2][R_W-1:0]};
                endcase
                mul_b = mul_a;
                if (cnt_reg != 5'd0)
                begin
                    acc_next = acc_reg + SUM_W'(prod_reg);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    res_next   = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    state_next = S_QR;
                end
            end
            S_QR:
            begin
                if (acc_reg >= trial_sum)
                begin
                    acc_next = acc_reg - trial_sum;
                    res_new  = (res_reg >> 1) + bit_reg;
                end
                res_next = res_new;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next   = res_new[LEN_W-1:0];
                    kk_next    = 2'd0;
                    state_next = S_QDM;
                end
            end
            S_QDM:
            begin
                mul_a = {{(MUL_W-THICK_W){1'b0}}, thick};
                case (kk_reg)
                    2'd0:    mul_b = {1'b0, r_reg[0][R_W-1:0]};
                    2'd1:    mul_b = {1'b0, r_reg[1][R_W-1:0]};
                    default: mul_b = {1'b0, r_reg[2][R_W-1:0]};
                endcase
                state_next = S_QDL;
            end
            S_QDL:
            begin
                num        = {prod_reg[NUM_W-2:0], 1'b0} + NUM_W'(len_reg);
                rem_next   = REM_W'(num[NUM_W-1:QUO_W]);
                numlo_next = num[QUO_W-1:0];
                quo_next   = '0;
                cnt_next   = 5'd0;
                state_next = S_QDV;
            end
            S_QDV:
            begin
                numlo_next = numlo_reg << 1;
                if (trial >= dvs)
                begin
                    rem_next   = trial - dvs;
                    quo_new[0] = 1'b1;
                end
                else
                begin
                    rem_next = trial;
                end
                quo_next = quo_new;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    q_next[kk_reg] = quo_new;
                    if (kk_reg == 2'd2)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sub = (i == 2) ? (neg_reg[2] ^ !sign_cfg) :
                                  (neg_reg[i] ^ !sign_cfg);
                            if (i == 2)
                                ext = {{3{pa_reg[2][COORD_W-1]}}, pa_reg[2]} +
                                      (sub ? -(COORD_W+3)'({1'b0, quo_new}) :
                                             (COORD_W+3)'({1'b0, quo_new}));
                            else
                                ext = {{3{pa_reg[i][COORD_W-1]}}, pa_reg[i]} +
                                      (sub ? -(COORD_W+3)'({1'b0, q_reg[i]}) :
                                             (COORD_W+3)'({1'b0, q_reg[i]}));
                            off_next[i] = sat24(ext);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        kk_next    = kk_reg + 2'd1;
                        state_next = S_QDM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            kk_reg    <= 2'd0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            kk_reg    <= kk_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        off_reg    <= off_next;
        pa_reg     <= pa_next;
        u_reg      <= u_next;
        w_reg      <= w_next;
        n_reg      <= n_next;
        prod_reg   <= prod_next;
        r_reg      <= r_next;
        neg_reg    <= neg_next;
        m_reg      <= m_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        quo_reg    <= quo_next;
        q_reg      <= q_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign off_x  = off_reg[0];
    assign off_y  = off_reg[1];
    assign off_z  = off_reg[2];

endmodule

>>> design/vertex_normal_inward_offset.sv
// Offsets mesh vertices along their area-weighted normals, inward by default; a set sign
// configuration bit reverses the direction. Every accepted item gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall, so it must take each result in the
// cycle it appears. Items are taken while busy is low into a two-entry queue and run one at a
// time. A load, an unknown kind or a rejected face or query gives its result from the dispatch
// state, and a query with a zero normal from the magnitude check. A face takes three position
// reads, six products through one shared multiplier and three read-modify-writes of the normal
// sums. A query runs the normalizing shifts, the one-bit-per-step square root and three
// 25-step divisions.
// Configuration must only be written while the block is idle.
module vertex_normal_inward_offset (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic [vnio_pkg::IDX_W-1:0]          vertex_index,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_x,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_y,
    input  logic signed [vnio_pkg::COORD_W-1:0] pos_in_z,
    input  logic [vnio_pkg::IDX_W-1:0]          corner_a,
    input  logic [vnio_pkg::IDX_W-1:0]          corner_b,
    input  logic [vnio_pkg::IDX_W-1:0]          corner_c,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [vnio_pkg::COORD_W-1:0] off_x,
    output logic signed [vnio_pkg::COORD_W-1:0] off_y,
    output logic signed [vnio_pkg::COORD_W-1:0] off_z,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [vnio_pkg::THICK_W-1:0]        cfg_data
);
    import vnio_pkg::*;

    item_t                q_item;
    logic                 q_valid;
    logic                 q_pop;
    logic [THICK_W-1:0]   thick_reg;
    logic                 sign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thick_reg <= THICK_RESET;
            sign_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THICK: thick_reg <= cfg_data;
                CFG_SIGN:  sign_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    vnio_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .vertex_index (vertex_index),
        .pos_in_x     (pos_in_x),
        .pos_in_y     (pos_in_y),
        .pos_in_z     (pos_in_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    vnio_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .thick    (thick_reg),
        .sign_cfg (sign_reg),
        .done     (done),
        .status   (status),
        .off_x    (off_x),
        .off_y    (off_y),
        .off_z    (off_z)
    );

endmodule

>>> design/vnio_checker.sv
module vnio_props (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [1:0]                          status,
    input logic signed [vnio_pkg::COORD_W-1:0] off_x,
    input logic signed [vnio_pkg::COORD_W-1:0] off_y,
    input logic signed [vnio_pkg::COORD_W-1:0] off_z
);
    import vnio_pkg::*;

    // Every item passes through the idle and dispatch states of the back end, so two results never come back to back.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on back-to-back cycles");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (off_x == '0 && off_y == '0 && off_z == '0))
        else $error("offset nonzero on a failed item");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transfer");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start) |=> !(busy && done && $past(done)))
        else $error("queue state inconsistent with results");

endmodule

bind vertex_normal_inward_offset vnio_props u_vnio_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .off_x  (off_x),
    .off_y  (off_y),
    .off_z  (off_z)
);
